// File: design/md4_pkg.sv
// Shared constants, types and round helpers for the MD4 stream hasher.
package md4_pkg;

	typedef logic [31:0] word_t;

	// Chain value at the start of every message
	localparam word_t INIT_A = 32'h67452301;
	localparam word_t INIT_B = 32'hefcdab89;
	localparam word_t INIT_C = 32'h98badcfe;
	localparam word_t INIT_D = 32'h10325476;

	// Additive constants of the second and third passes
	localparam word_t K2 = 32'h5a827999;
	localparam word_t K3 = 32'h6ed9eba1;

	// Padding marker byte
	localparam logic [7:0] PAD_BYTE = 8'h80;

	// Block word used by a given round
	function automatic logic [3:0] msg_idx(input logic [5:0] rnd);
		logic [3:0] idx;
		case (rnd[5:4])
			2'd0: idx = rnd[3:0];
			2'd1: idx = {rnd[1:0], rnd[3:2]};
			default: idx = {rnd[0], rnd[1], rnd[2], rnd[3]};
		endcase
		return idx;
	endfunction

	// Rotate amount of a given round
	function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
		logic [4:0] s;
		case ({rnd[5:4], rnd[1:0]})
			4'b0000: s = 5'd3;
			4'b0001: s = 5'd7;
			4'b0010: s = 5'd11;
			4'b0011: s = 5'd19;
			4'b0100: s = 5'd3;
			4'b0101: s = 5'd5;
			4'b0110: s = 5'd9;
			4'b0111: s = 5'd13;
			4'b1000: s = 5'd3;
			4'b1001: s = 5'd9;
			4'b1010: s = 5'd11;
			4'b1011: s = 5'd15;
			default: s = 5'd3;
		endcase
		return s;
	endfunction

	// Left rotate of a 32-bit word
	function automatic word_t rotl(input word_t v, input logic [4:0] s);
		word_t res;
		res = (v << s) | (v >> (6'd32 - {1'b0, s}));
		return res;
	endfunction

endpackage

// File: design/md4_in_if.sv
// Byte input channel: one message byte or end marker per transfer.
interface md4_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       is_last;

	modport source (output valid, data_byte, byte_valid, is_last, input ready);
	modport sink   (input valid, data_byte, byte_valid, is_last, output ready);
endinterface

// File: design/md4_out_if.sv
// Digest output channel: four chain words per transfer.
interface md4_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word0;
	logic [31:0] digest_word1;
	logic [31:0] digest_word2;
	logic [31:0] digest_word3;

	modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
		input ready);
	modport sink   (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
		output ready);
endinterface

// File: design/md4_stream_hash.sv
// MD4 stream hasher: byte input, 128-bit digest per message.
//
// byte_in takes one transfer per message byte (byte_valid = 1); is_last marks the
// final transfer, which may carry no byte so that empty messages work. A transfer
// with neither byte nor end marker is ignored. digest_out gives one transfer of
// four chain words (A..D, each little-endian) per message.
// Bytes are taken in one per cycle while idle and packed into a 32-bit assembly
// word; full words go to a 16 x 32 block memory with a registered read port.
// When 64 bytes are held, byte_in stalls while the chain is loaded and the first
// word fetched, 48 rounds run at one per cycle (the round unit reads one block
// word a cycle), and the chain is updated.
// End of message: pad, zero/length fill of the remaining words before the first
// compression (a whole block more when 56 or more bytes are pending and the
// padding spills), the compressions, then the digest hand-off to the output
// register. The digest register frees byte_in at once, so the next message
// streams while a stalled receiver holds the digest; only a second digest waits.
// Reset (arst_n low) restores the initial chain, zero bit count and position.
// Block memory contents are not cleared; every word is written before use.
module md4_stream_hash (
	input  logic         clk,
	input  logic         arst_n,
	md4_in_if.sink       byte_in,
	md4_out_if.source    digest_out
);

	// Sequencer codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_ZERO  = 3'd2;
	localparam logic [2:0] ST_LOAD  = 3'd3;
	localparam logic [2:0] ST_ROUND = 3'd4;
	localparam logic [2:0] ST_ADD   = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	localparam logic [5:0] LAST_ROUND = 6'd47;

	logic [2:0]         state_q;
	logic [2:0]         next_q;
	logic [5:0]         pos_q;
	logic [63:0]        bits_q;
	md4_pkg::word_t     word_q;
	md4_pkg::word_t     chain_q [4];
	md4_pkg::word_t     ra_q, rb_q, rc_q, rd_q;
	logic [5:0]         rnd_q;
	logic [3:0]         widx_q;
	logic               two_q;
	md4_pkg::word_t     digest_q [4];
	logic               dvalid_q;

	// Block memory
	md4_pkg::word_t     blk_mem [16];
	md4_pkg::word_t     rdata_q;
	logic               mem_we;
	logic [3:0]         mem_waddr;
	md4_pkg::word_t     mem_wdata;
	logic [3:0]         mem_raddr;

	logic               in_acc;
	logic               out_free;
	md4_pkg::word_t     byte_word;
	md4_pkg::word_t     pad_word;
	md4_pkg::word_t     fill_word;
	md4_pkg::word_t     f_val;
	md4_pkg::word_t     k_val;
	md4_pkg::word_t     round_sum;
	md4_pkg::word_t     round_new;

	assign byte_in.ready = (state_q == ST_IDLE);
	assign in_acc = byte_in.valid && byte_in.ready;
	assign out_free = !dvalid_q || digest_out.ready;

	assign digest_out.valid = dvalid_q;
	assign digest_out.digest_word0 = digest_q[0];
	assign digest_out.digest_word1 = digest_q[1];
	assign digest_out.digest_word2 = digest_q[2];
	assign digest_out.digest_word3 = digest_q[3];

	// Byte insertion into the assembly word, and the padding word
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			if (pos_q[1:0] == l[1:0]) begin
				byte_word[8*l +: 8] = byte_in.data_byte;
				pad_word[8*l +: 8] = md4_pkg::PAD_BYTE;
			end else if (l[1:0] < pos_q[1:0]) begin
				byte_word[8*l +: 8] = word_q[8*l +: 8];
				pad_word[8*l +: 8] = word_q[8*l +: 8];
			end else begin
				byte_word[8*l +: 8] = word_q[8*l +: 8];
				pad_word[8*l +: 8] = 8'h00;
			end
		end
	end

	// Fill word: zero, or the bit count in the last two words of the final block
	always_comb begin
		fill_word = '0;
		if (!two_q && widx_q == 4'd14) begin
			fill_word = bits_q[31:0];
		end else if (!two_q && widx_q == 4'd15) begin
			fill_word = bits_q[63:32];
		end
	end

	// Memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = pos_q[5:2];
		mem_wdata = byte_word;
		case (state_q)
			ST_IDLE: begin
				mem_we = in_acc && byte_in.byte_valid && (pos_q[1:0] == 2'd3);
			end
			ST_PAD: begin
				mem_we = 1'b1;
				mem_wdata = pad_word;
			end
			ST_ZERO: begin
				mem_we = 1'b1;
				mem_waddr = widx_q;
				mem_wdata = fill_word;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
		if (state_q == ST_ROUND) begin
			mem_raddr = md4_pkg::msg_idx(rnd_q + 6'd1);
		end else begin
			mem_raddr = md4_pkg::msg_idx(rnd_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			blk_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= blk_mem[mem_raddr];
	end

	// One compression round; rb, rc, rd are the three inputs of the round function
	always_comb begin
		case (rnd_q[5:4])
			2'd0: begin
				f_val = rd_q ^ (rb_q & (rc_q ^ rd_q));
				k_val = '0;
			end
			2'd1: begin
				f_val = (rb_q & rc_q) | (rb_q & rd_q) | (rc_q & rd_q);
				k_val = md4_pkg::K2;
			end
			default: begin
				f_val = rb_q ^ rc_q ^ rd_q;
				k_val = md4_pkg::K3;
			end
		endcase
		round_sum = ra_q + f_val + rdata_q + k_val;
		round_new = md4_pkg::rotl(round_sum, md4_pkg::rot_amount(rnd_q));
	end

	// Sequencer, counters and chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			next_q <= ST_IDLE;
			pos_q <= '0;
			bits_q <= '0;
			rnd_q <= '0;
			widx_q <= '0;
			two_q <= 1'b0;
			chain_q[0] <= md4_pkg::INIT_A;
			chain_q[1] <= md4_pkg::INIT_B;
			chain_q[2] <= md4_pkg::INIT_C;
			chain_q[3] <= md4_pkg::INIT_D;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (byte_in.byte_valid) begin
							pos_q <= pos_q + 6'd1;
							bits_q <= bits_q + 64'd8;
							if (pos_q == 6'd63) begin
								state_q <= ST_LOAD;
								next_q <= byte_in.is_last ? ST_PAD : ST_IDLE;
							end else if (byte_in.is_last) begin
								state_q <= ST_PAD;
							end
						end else if (byte_in.is_last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					two_q <= (pos_q[5:3] == 3'd7);
					if (pos_q[5:2] == 4'd15) begin
						state_q <= ST_LOAD;
						next_q <= ST_ZERO;
					end else begin
						widx_q <= pos_q[5:2] + 4'd1;
						state_q <= ST_ZERO;
					end
				end
				ST_ZERO: begin
					if (widx_q == 4'd15) begin
						state_q <= ST_LOAD;
						next_q <= two_q ? ST_ZERO : ST_FIN;
					end else begin
						widx_q <= widx_q + 4'd1;
					end
				end
				ST_LOAD: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == LAST_ROUND) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					chain_q[0] <= chain_q[0] + ra_q;
					chain_q[1] <= chain_q[1] + rb_q;
					chain_q[2] <= chain_q[2] + rc_q;
					chain_q[3] <= chain_q[3] + rd_q;
					rnd_q <= '0;
					state_q <= next_q;
					if (next_q == ST_ZERO) begin
						widx_q <= '0;
						two_q <= 1'b0;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						chain_q[0] <= md4_pkg::INIT_A;
						chain_q[1] <= md4_pkg::INIT_B;
						chain_q[2] <= md4_pkg::INIT_C;
						chain_q[3] <= md4_pkg::INIT_D;
						bits_q <= '0;
						pos_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Digest valid: set when the finished chain is loaded, cleared on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvalid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			dvalid_q <= 1'b1;
		end else if (digest_out.ready) begin
			dvalid_q <= 1'b0;
		end
	end

	// Assembly word, working registers and digest payload
	always_ff @(posedge clk) begin
		if (in_acc && byte_in.byte_valid) begin
			word_q <= byte_word;
		end
		if (state_q == ST_LOAD) begin
			ra_q <= chain_q[0];
			rb_q <= chain_q[1];
			rc_q <= chain_q[2];
			rd_q <= chain_q[3];
		end else if (state_q == ST_ROUND) begin
			ra_q <= rd_q;
			rb_q <= round_new;
			rc_q <= rb_q;
			rd_q <= rc_q;
		end
		if (state_q == ST_FIN && out_free) begin
			for (int i = 0; i < 4; i++) begin
				digest_q[i] <= chain_q[i];
			end
		end
	end

endmodule
